>>> design/wsts_pkg.sv
// Shared constants for the work-stealing task scheduler: sizes, field widths,
// command and status codes, configuration register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsts_pkg;

    localparam int MAX_THREADS = 1024;
    localparam int MAX_WORKERS = 8;

    localparam int TID_W  = $clog2(MAX_THREADS);
    localparam int ID_W   = TID_W + 1;
    localparam int WK_W   = $clog2(MAX_WORKERS);
    localparam int RS_W   = WK_W + 1;
    localparam int CNT_W  = TID_W;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;
    localparam int WC_W   = 4;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_YIELD    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT     = 2'd3;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_NONE       = 3'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_CURRENT = 3'd3;
    localparam logic [ST_W-1:0] ST_BUSY       = 3'd4;

    // register word index
    localparam logic REG_WORKER_COUNT = 1'b0;
    localparam logic [WC_W-1:0] WC_RESET = 4'd4;

endpackage

`default_nettype wire

>>> design/wsts_if.sv
// Handshake channels of the scheduler: command in, result out.
// Depends on wsts_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wsts_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [wsts_pkg::CMD_W-1:0] command;
    logic [wsts_pkg::WK_W-1:0]  worker;

    modport source (output valid, command, worker, input ready);
    modport sink   (input valid, command, worker, output ready);
endinterface

interface wsts_res_if;
    logic                       valid;
    logic                       ready;
    logic [wsts_pkg::ST_W-1:0]  status;
    logic [wsts_pkg::TID_W-1:0] thread_id;
    logic [wsts_pkg::WK_W-1:0]  worker_used;
    logic                       stolen;
    logic [wsts_pkg::CNT_W-1:0] active_count;

    modport source (output valid, status, thread_id, worker_used, stolen, active_count,
                    input ready);
    modport sink   (input valid, status, thread_id, worker_used, stolen, active_count,
                    output ready);
endinterface

`default_nettype wire

>>> design/wsts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/work_stealing_task_scheduler.sv
// Work-stealing task scheduler: one linked-list FIFO per worker, links kept in a
// RAM indexed by thread id. A command is accepted only when the sequencer is idle
// and is answered by exactly one result transaction. Create and yield clear the
// new tail's link and, when the target queue is not empty, make a second RAM write
// for the old tail's link. Dispatch scans k queues of the ring (1..ring size), one
// per cycle, plus a link read when a thread is found.
// The finished result sits in an output register, so the next command can be taken
// while the previous result is still waiting. The ring size register sits at byte
// address 0.
// Depends on wsts_pkg, wsts_if and wsts_ram.
`timescale 1ns / 1ps
`default_nettype none

module work_stealing_task_scheduler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    wsts_cmd_if.sink                            i_cmd,
    wsts_res_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wsts_pkg::APB_AW-1:0]    paddr,
    input  wire logic [wsts_pkg::APB_DW-1:0]    pwdata,
    output logic      [wsts_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_POP,
        S_PUSH,
        S_LINK,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [wsts_pkg::CMD_W-1:0]      r_cmd;
    logic [wsts_pkg::WK_W-1:0]       r_w;
    logic [wsts_pkg::WK_W-1:0]       r_q;
    logic [wsts_pkg::RS_W-1:0]       r_i;
    logic [wsts_pkg::TID_W-1:0]      r_tid;
    logic [wsts_pkg::ST_W-1:0]       r_status;
    logic [wsts_pkg::WK_W-1:0]       r_used;
    logic                            r_stolen;
    logic [wsts_pkg::ID_W-1:0]       r_next_id;
    logic [wsts_pkg::WK_W-1:0]       r_place;
    logic [wsts_pkg::TID_W-1:0]      r_head [wsts_pkg::MAX_WORKERS];
    logic [wsts_pkg::TID_W-1:0]      r_tail [wsts_pkg::MAX_WORKERS];
    logic [wsts_pkg::TID_W-1:0]      r_cur  [wsts_pkg::MAX_WORKERS];
    logic [wsts_pkg::CNT_W-1:0]      r_active;
    logic [wsts_pkg::WC_W-1:0]       r_wc;

    logic                            r_ovalid;
    logic [wsts_pkg::ST_W-1:0]       r_ostatus;
    logic [wsts_pkg::TID_W-1:0]      r_otid;
    logic [wsts_pkg::WK_W-1:0]       r_oused;
    logic                            r_ostolen;
    logic [wsts_pkg::CNT_W-1:0]      r_oactive;

    logic [wsts_pkg::RS_W-1:0]       ring_n;
    logic [wsts_pkg::WK_W-1:0]       place_p;
    logic [wsts_pkg::WK_W-1:0]       n_place;
    logic [wsts_pkg::WK_W-1:0]       n_q;
    logic                            cfg_wr;
    logic                            ram_we;
    logic [wsts_pkg::TID_W-1:0]      ram_waddr;
    logic [wsts_pkg::TID_W-1:0]      ram_wdata;
    logic [wsts_pkg::TID_W-1:0]      ram_rdata;

    // ring size clamps to 1..MAX_WORKERS
    always_comb begin
        if (r_wc == '0) begin
            ring_n = wsts_pkg::RS_W'(1);
        end else if (r_wc > wsts_pkg::WC_W'(wsts_pkg::MAX_WORKERS)) begin
            ring_n = wsts_pkg::RS_W'(wsts_pkg::MAX_WORKERS);
        end else begin
            ring_n = wsts_pkg::RS_W'(r_wc);
        end
    end

    // placement restarts at 0 if the ring shrank below the pointer
    assign place_p = ({1'b0, r_place} < ring_n) ? r_place : '0;
    assign n_place = (({1'b0, place_p} + wsts_pkg::RS_W'(1)) >= ring_n)
                     ? '0 : place_p + wsts_pkg::WK_W'(1);
    assign n_q     = (({1'b0, r_q} + wsts_pkg::RS_W'(1)) >= ring_n)
                     ? '0 : r_q + wsts_pkg::WK_W'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_tid;
        ram_wdata = '0;
        case (r_state)
            S_PUSH: begin
                ram_we = 1'b1;
            end
            S_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail[r_q];
                ram_wdata = r_tid;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    wsts_ram #(
        .WIDTH (wsts_pkg::TID_W),
        .DEPTH (wsts_pkg::MAX_THREADS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[r_q]),
        .o_rdata (ram_rdata)
    );

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[wsts_pkg::APB_AW-1:2] == wsts_pkg::REG_WORKER_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[wsts_pkg::APB_AW-1:2] == wsts_pkg::REG_WORKER_COUNT)
                    ? wsts_pkg::APB_DW'(r_wc) : '0;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_ostatus;
    assign o_res.thread_id    = r_otid;
    assign o_res.worker_used  = r_oused;
    assign o_res.stolen       = r_ostolen;
    assign o_res.active_count = r_oactive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next_id <= wsts_pkg::ID_W'(1);
            r_place   <= '0;
            r_active  <= '0;
            r_wc      <= wsts_pkg::WC_RESET;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < wsts_pkg::MAX_WORKERS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cur[k]  <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_wc <= pwdata[wsts_pkg::WC_W-1:0];
            end
            // in S_FIN the output register is either reloaded or held
            if (r_ovalid && o_res.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd    <= i_cmd.command;
                        r_w      <= i_cmd.worker;
                        r_q      <= (i_cmd.command == wsts_pkg::CMD_CREATE)
                                    ? place_p : i_cmd.worker;
                        r_i      <= '0;
                        r_tid    <= '0;
                        r_status <= wsts_pkg::ST_OK;
                        r_used   <= '0;
                        r_stolen <= 1'b0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd)
                        wsts_pkg::CMD_CREATE: begin
                            if (r_next_id >= wsts_pkg::ID_W'(wsts_pkg::MAX_THREADS)) begin
                                r_status <= wsts_pkg::ST_EXHAUSTED;
                                r_state  <= S_FIN;
                            end else begin
                                r_tid     <= r_next_id[wsts_pkg::TID_W-1:0];
                                r_next_id <= r_next_id + wsts_pkg::ID_W'(1);
                                r_active  <= r_active + wsts_pkg::CNT_W'(1);
                                r_used    <= r_q;
                                r_place   <= n_place;
                                r_state   <= S_PUSH;
                            end
                        end
                        wsts_pkg::CMD_DISPATCH: begin
                            if ({1'b0, r_w} >= ring_n) begin
                                r_status <= wsts_pkg::ST_NONE;
                                r_state  <= S_FIN;
                            end else if (r_cur[r_w] != '0) begin
                                r_status <= wsts_pkg::ST_BUSY;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            if (r_cur[r_w] == '0) begin
                                r_status <= wsts_pkg::ST_NO_CURRENT;
                                r_state  <= S_FIN;
                            end else begin
                                r_tid      <= r_cur[r_w];
                                r_cur[r_w] <= '0;
                                if (r_cmd == wsts_pkg::CMD_YIELD) begin
                                    r_state <= S_PUSH;
                                end else begin
                                    if (r_active != '0) begin
                                        r_active <= r_active - wsts_pkg::CNT_W'(1);
                                    end
                                    r_state <= S_FIN;
                                end
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    // link RAM read of the head is issued in this cycle
                    if (r_head[r_q] != '0) begin
                        r_tid    <= r_head[r_q];
                        r_used   <= r_q;
                        r_stolen <= (r_i != '0);
                        r_state  <= S_POP;
                    end else if ((r_i + wsts_pkg::RS_W'(1)) >= ring_n) begin
                        r_status <= wsts_pkg::ST_NONE;
                        r_state  <= S_FIN;
                    end else begin
                        r_i <= r_i + wsts_pkg::RS_W'(1);
                        r_q <= n_q;
                    end
                end
                S_POP: begin
                    r_head[r_q] <= ram_rdata;
                    if (ram_rdata == '0) begin
                        r_tail[r_q] <= '0;
                    end
                    r_cur[r_w] <= r_tid;
                    r_state    <= S_FIN;
                end
                S_PUSH: begin
                    // link of the new tail cleared in this cycle
                    if (r_head[r_q] == '0) begin
                        r_head[r_q] <= r_tid;
                        r_tail[r_q] <= r_tid;
                        r_state     <= S_FIN;
                    end else begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_tail[r_q] <= r_tid;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_otid    <= r_tid;
                        r_oused   <= r_used;
                        r_ostolen <= r_stolen;
                        r_oactive <= r_active;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/wsts_checker.sv
// Port-level assertions for the work-stealing task scheduler, bound to its top.
// Depends on wsts_pkg and work_stealing_task_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module wsts_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [wsts_pkg::ST_W-1:0]   i_status,
    input wire logic [wsts_pkg::TID_W-1:0]  i_thread_id,
    input wire logic [wsts_pkg::WK_W-1:0]   i_worker_used,
    input wire logic                        i_stolen
);

    // one command in flight: busy right after a transaction is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_thread_id))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != wsts_pkg::ST_OK)
            |-> (i_thread_id == '0) && (i_worker_used == '0) && !i_stolen)
        else $error("failed command reports a thread");

    a_ok_has_thread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == wsts_pkg::ST_OK) || i_stolen)
            |-> (i_thread_id != '0) && (i_status == wsts_pkg::ST_OK))
        else $error("successful command without thread id");

endmodule

bind work_stealing_task_scheduler wsts_checker u_wsts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_thread_id   (o_res.thread_id),
    .i_worker_used (o_res.worker_used),
    .i_stolen      (o_res.stolen)
);

`default_nettype wire

>>> bench/testbench.sv
// Testbench for work_stealing_task_scheduler: random and directed scheduler commands,
// results checked against an in-bench scheduler model. Depends on wsts_pkg, wsts_if
// and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES  = 16;    // slowest command is a full-ring dispatch
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLD_OFF       = 400;
    localparam int PRINT_LIMIT    = 40;
    localparam int PHASE_ITEMS    = 30;

    typedef struct packed {
        logic [wsts_pkg::CMD_W-1:0] command;
        logic [wsts_pkg::WK_W-1:0]  worker;
    } t_sched_cmd;

    typedef struct packed {
        logic [wsts_pkg::ST_W-1:0]  status;
        logic [wsts_pkg::TID_W-1:0] thread_id;
        logic [wsts_pkg::WK_W-1:0]  worker_used;
        logic                       stolen;
        logic [wsts_pkg::CNT_W-1:0] active_count;
    } t_sched_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [wsts_pkg::APB_AW-1:0]   paddr;
    logic [wsts_pkg::APB_DW-1:0]   pwdata;
    logic [wsts_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    wsts_cmd_if cmd_ch ();
    wsts_res_if res_ch ();

    work_stealing_task_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scheduler model state
    logic [wsts_pkg::WC_W-1:0]  wc_cfg = wsts_pkg::WC_RESET;
    logic [wsts_pkg::ID_W-1:0]  id_counter = 1;
    int                         place_ptr = 0;
    logic [wsts_pkg::CNT_W-1:0] live_count = '0;
    logic [wsts_pkg::TID_W-1:0] ready_head [wsts_pkg::MAX_WORKERS] = '{default: '0};
    logic [wsts_pkg::TID_W-1:0] ready_tail [wsts_pkg::MAX_WORKERS] = '{default: '0};
    logic [wsts_pkg::TID_W-1:0] running    [wsts_pkg::MAX_WORKERS] = '{default: '0};
    logic [wsts_pkg::TID_W-1:0] link_next  [wsts_pkg::MAX_THREADS] = '{default: '0};

    t_sched_cmd    pending_cmds[$];
    t_sched_result expected_results[$];
    int            creates_issued = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    int            hold_left = 0;
    logic          hold_request = 1'b0;
    logic          steady_flow = 1'b0;
    logic          cmd_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int ring_size();
        if (wc_cfg == 0) return 1;
        if (wc_cfg > wsts_pkg::MAX_WORKERS) return wsts_pkg::MAX_WORKERS;
        return int'(wc_cfg);
    endfunction

    function automatic void append_ready(input int q, input logic [wsts_pkg::TID_W-1:0] tid);
        link_next[tid] = '0;
        if (ready_head[q] == 0)
            ready_head[q] = tid;
        else
            link_next[ready_tail[q]] = tid;
        ready_tail[q] = tid;
    endfunction

    function automatic t_sched_result schedule_step(input t_sched_cmd item);
        t_sched_result              r;
        int                         ring;
        int                         slot;
        int                         src;
        logic [wsts_pkg::TID_W-1:0] tid;
        r = '0;
        ring = ring_size();
        case (item.command)
            wsts_pkg::CMD_CREATE: begin
                if (id_counter >= wsts_pkg::MAX_THREADS) begin
                    id_counter = wsts_pkg::MAX_THREADS;
                    r.status = wsts_pkg::ST_EXHAUSTED;
                end else begin
                    // pointer left over from a wider ring restarts at worker 0
                    slot = (place_ptr < ring) ? place_ptr : 0;
                    r.thread_id = id_counter[wsts_pkg::TID_W-1:0];
                    id_counter = id_counter + 1'b1;
                    live_count = live_count + 1'b1;
                    append_ready(slot, r.thread_id);
                    r.worker_used = slot[wsts_pkg::WK_W-1:0];
                    place_ptr = (slot + 1 >= ring) ? 0 : slot + 1;
                end
            end
            wsts_pkg::CMD_DISPATCH: begin
                if (int'(item.worker) >= ring) begin
                    r.status = wsts_pkg::ST_NONE;
                end else if (running[item.worker] != 0) begin
                    r.status = wsts_pkg::ST_BUSY;
                end else begin
                    r.status = wsts_pkg::ST_NONE;
                    for (int i = 0; i < ring; i++) begin
                        src = (int'(item.worker) + i) % ring;
                        tid = ready_head[src];
                        if (tid != 0) begin
                            ready_head[src] = link_next[tid];
                            if (ready_head[src] == 0) ready_tail[src] = '0;
                            running[item.worker] = tid;
                            r.status = wsts_pkg::ST_OK;
                            r.thread_id = tid;
                            r.worker_used = src[wsts_pkg::WK_W-1:0];
                            r.stolen = (i != 0);
                            break;
                        end
                    end
                end
            end
            default: begin
                // yield and exit act on the worker's thread even outside the ring
                if (running[item.worker] == 0) begin
                    r.status = wsts_pkg::ST_NO_CURRENT;
                end else begin
                    r.thread_id = running[item.worker];
                    running[item.worker] = '0;
                    if (item.command == wsts_pkg::CMD_YIELD)
                        append_ready(int'(item.worker), r.thread_id);
                    else if (live_count > 0)
                        live_count = live_count - 1'b1;
                end
            end
        endcase
        r.active_count = live_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void add_cmd(input logic [wsts_pkg::CMD_W-1:0] command,
                                    input logic [wsts_pkg::WK_W-1:0] worker);
        t_sched_cmd item;
        item.command = command;
        item.worker = worker;
        pending_cmds.push_back(item);
        if (command == wsts_pkg::CMD_CREATE) creates_issued++;
    endfunction

    function automatic void add_random_cmds(input int count, input int create_pct);
        int                         ring;
        int                         roll;
        logic [wsts_pkg::CMD_W-1:0] command;
        logic [wsts_pkg::WK_W-1:0]  worker;
        ring = ring_size();
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < create_pct) begin
                command = wsts_pkg::CMD_CREATE;
            end else begin
                roll = $urandom_range(0, 3);
                command = (roll < 2) ? wsts_pkg::CMD_DISPATCH
                        : (roll == 2) ? wsts_pkg::CMD_YIELD : wsts_pkg::CMD_EXIT;
            end
            // mostly workers in the ring, some from anywhere
            if ($urandom_range(0, 99) < 85)
                worker = wsts_pkg::WK_W'($urandom_range(0, ring - 1));
            else
                worker = wsts_pkg::WK_W'($urandom_range(0, wsts_pkg::MAX_WORKERS - 1));
            add_cmd(command, worker);
        end
    endfunction

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_cmds.size() != 0 || cmd_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [wsts_pkg::WC_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {wsts_pkg::REG_WORKER_COUNT, 2'b00};
        pwdata <= {{(wsts_pkg::APB_DW - wsts_pkg::WC_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        wc_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[wsts_pkg::WC_W-1:0] !== value)
            report_mismatch("ring size readback", int'(prdata[wsts_pkg::WC_W-1:0]),
                            int'(value));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // command driver
    always @(negedge i_clk) begin
        t_sched_cmd item;
        if (!cmd_ch.valid || cmd_taken) begin
            if (pending_cmds.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 30)) begin
                item = pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= item.command;
                cmd_ch.worker <= item.worker;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 30);
        end
    end

    // monitor: checks results, predicts accepted commands, watchdog
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        t_sched_cmd    item;
        cmd_taken <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        if (i_rst_n) begin
            quiet_cycles++;
            if (res_ch.valid && res_ch.ready) begin
                quiet_cycles = 0;
                got.status = res_ch.status;
                got.thread_id = res_ch.thread_id;
                got.worker_used = res_ch.worker_used;
                got.stolen = res_ch.stolen;
                got.active_count = res_ch.active_count;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transaction, thread_id",
                                    int'(got.thread_id), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.thread_id !== want.thread_id)
                        report_mismatch("thread_id", int'(got.thread_id), int'(want.thread_id));
                    if (got.worker_used !== want.worker_used)
                        report_mismatch("worker_used", int'(got.worker_used),
                                        int'(want.worker_used));
                    if (got.stolen !== want.stolen)
                        report_mismatch("stolen", int'(got.stolen), int'(want.stolen));
                    if (got.active_count !== want.active_count)
                        report_mismatch("active_count", int'(got.active_count),
                                        int'(want.active_count));
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                quiet_cycles = 0;
                item.command = cmd_ch.command;
                item.worker = cmd_ch.worker;
                expected_results.push_back(schedule_step(item));
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int wc_plan [11];
        int create_plan [11];
        wc_plan = '{1, 8, 0, 15, 3, 8, 6, 2, 5, 7, 8};
        create_plan = '{70, 60, 25, 70, 55, 80, 40, 70, 65, 75, 85};
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = wsts_pkg::CMD_CREATE;
        cmd_ch.worker = '0;
        res_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, missing current thread, placement, busy, stealing
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd0);
        add_cmd(wsts_pkg::CMD_YIELD, 3'd0);
        add_cmd(wsts_pkg::CMD_EXIT, 3'd7);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd7);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd0);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd5);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd2);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd1);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd0);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd0);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd6);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd3);
        add_cmd(wsts_pkg::CMD_EXIT, 3'd3);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd3);
        write_ring_size(4'd8);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd4);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd3);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd6);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd6);
        // shrink below the placement pointer; worker 6 now sits outside the ring
        write_ring_size(4'd2);
        add_cmd(wsts_pkg::CMD_CREATE, 3'd0);
        add_cmd(wsts_pkg::CMD_YIELD, 3'd6);
        add_cmd(wsts_pkg::CMD_DISPATCH, 3'd6);

        for (int ph = 0; ph < 11; ph++) begin
            write_ring_size(wc_plan[ph][wsts_pkg::WC_W-1:0]);
            steady_flow = (ph == 5);
            if (ph == 7) begin
                add_random_cmds(PHASE_ITEMS / 2, create_plan[ph]);
                wait_idle();
                add_random_cmds(PHASE_ITEMS - PHASE_ITEMS / 2, create_plan[ph]);
            end else begin
                add_random_cmds(PHASE_ITEMS, create_plan[ph]);
            end
            if (ph == 1) hold_request = 1'b1;
        end

        // run the id counter out, then keep scheduling what is left
        while (creates_issued < wsts_pkg::MAX_THREADS + 16) add_random_cmds(20, 95);
        add_random_cmds(40, 0);

        wait_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
